// ===== rtl/povscan_pkg.sv =====
// ----------------------------------------------------------------------------
// povscan_pkg
// Shared types, sizes and codes of the POV column scan sequencer.
// ----------------------------------------------------------------------------
package povscan_pkg;

  // Frame store geometry
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_BYTES   = 16;
  localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int BYTE_W      = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  localparam int FADDR_W     = 1 + COL_W + BYTE_W;
  localparam int FDEPTH      = 2 ** FADDR_W;

  // Port widths
  localparam int KIND_W   = 3;
  localparam int RKIND_W  = 2;
  localparam int CIDX_W   = 3;
  localparam int CDATA_W  = 16;
  localparam int PERIOD_W = 16;

  // Arithmetic constants
  localparam logic [7:0]          BLANK_BYTE  = 8'hFF;
  localparam logic [PERIOD_W-1:0] DIM_OFFSET  = 16'd7;
  localparam logic [16:0]         RECIP3      = 17'h0AAAB;  // ceil(2^17 / 3)
  localparam int                  RECIP3_SHR  = 17;
  localparam logic [1:0]          SUB_FIRST   = 2'd2;
  localparam logic [7:0]          COL_BEFORE0 = 8'hFF;

  typedef enum logic [KIND_W-1:0] {
    KIND_WRITE   = 3'd0,
    KIND_TICK    = 3'd1,
    KIND_BYTE    = 3'd2,
    KIND_ENABLE  = 3'd3,
    KIND_DISABLE = 3'd4
  } kind_e;

  typedef enum logic [RKIND_W-1:0] {
    RES_ACK    = 2'd0,
    RES_COLUMN = 2'd1,
    RES_BYTE   = 2'd2
  } rkind_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_COLUMNS = 3'd0,
    CFG_BYTES   = 3'd1,
    CFG_THREE   = 3'd2,
    CFG_DIMMING = 3'd3,
    CFG_PERIOD  = 3'd4,
    CFG_SECOND  = 3'd5
  } cfg_e;

  // Result of one item, before the frame store data is merged in
  typedef struct packed {
    logic [RKIND_W-1:0]  kind;
    logic                latch;
    logic                start;
    logic                pvalid;
    logic [PERIOD_W-1:0] period;
    logic                sync;
    logic [7:0]          sbyte;
    logic                last;
    logic                use_ram;
  } res_t;

  // Frame store access from the control logic
  typedef struct packed {
    logic               we;
    logic [FADDR_W-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [FADDR_W-1:0] raddr;
  } fmem_t;

endpackage

// ===== rtl/povscan_ram.sv =====
// ----------------------------------------------------------------------------
// povscan_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module povscan_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/povscan_ctrl.sv =====
// ----------------------------------------------------------------------------
// povscan_ctrl
// Configuration registers, scan counters and per-item decode.
// ----------------------------------------------------------------------------
module povscan_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [povscan_pkg::CIDX_W-1:0] cfg_index_i,
  input  logic [povscan_pkg::CDATA_W-1:0] cfg_wdata_i,
  input  logic                           accept_i,
  input  logic [povscan_pkg::KIND_W-1:0] kind_i,
  input  logic                           plane_i,
  input  logic [6:0]                     column_addr_i,
  input  logic [3:0]                     byte_addr_i,
  input  logic [7:0]                     pixel_byte_i,
  output povscan_pkg::res_t              res_o,
  output povscan_pkg::fmem_t             fmem_o
);
  import povscan_pkg::*;

  // Configuration
  logic [7:0]          columns_q;
  logic [4:0]          bytes_q;
  logic                three_q;
  logic                dimming_q;
  logic [PERIOD_W-1:0] base_q;
  logic                second_q;

  // Scan state
  logic [7:0] col_q, col_d, col_n;
  logic [1:0] sub_q, sub_d;
  logic [3:0] bidx_q, bidx_d;
  logic       blank_q, blank_d;
  logic       en_q, en_d;

  logic [32:0]         prod3;
  logic [PERIOD_W-1:0] third;
  logic [PERIOD_W-1:0] half;
  logic [PERIOD_W-1:0] half_dim;
  logic [7:0]          rcol;
  logic [3:0]          rbyte;
  logic [4:0]          bnext;
  res_t                res;
  fmem_t               fm;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= 8'd128;
      bytes_q   <= 5'd6;
      three_q   <= 1'b0;
      dimming_q <= 1'b0;
      base_q    <= 16'hFFFF;
      second_q  <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_COLUMNS: columns_q <= cfg_wdata_i[7:0];
        CFG_BYTES:   bytes_q   <= cfg_wdata_i[4:0];
        CFG_THREE:   three_q   <= cfg_wdata_i[0];
        CFG_DIMMING: dimming_q <= cfg_wdata_i[0];
        CFG_PERIOD:  base_q    <= cfg_wdata_i;
        CFG_SECOND:  second_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Period candidates: base/3 by reciprocal, base/2 - 7 saturated at zero
  assign prod3    = 33'(base_q) * 33'(RECIP3);
  assign third    = prod3[RECIP3_SHR +: PERIOD_W];
  assign half     = base_q >> 1;
  assign half_dim = (half >= DIM_OFFSET) ? (half - DIM_OFFSET) : '0;

  always_comb begin
    col_d   = col_q;
    col_n   = col_q;
    sub_d   = sub_q;
    bidx_d  = bidx_q;
    blank_d = blank_q;
    en_d    = en_q;
    res     = '0;
    fm      = '0;
    rcol    = columns_q - col_q;
    rbyte   = bidx_q;
    bnext   = {1'b0, bidx_q} + 5'd1;

    if (32'(rcol) >= 32'(columns_q) || 32'(rcol) >= MAX_COLUMNS) begin
      rcol = '0;
    end
    if (32'(rbyte) >= MAX_BYTES) begin
      rbyte = '0;
    end

    case (kind_i)
      KIND_WRITE: begin
        if (32'(column_addr_i) < MAX_COLUMNS && 32'(byte_addr_i) < MAX_BYTES) begin
          fm.we = 1'b1;
        end
        fm.waddr = {plane_i, COL_W'(column_addr_i), BYTE_W'(byte_addr_i)};
        fm.wdata = pixel_byte_i;
      end
      KIND_TICK: begin
        res.kind  = RES_COLUMN;
        res.latch = 1'b1;
        if (dimming_q) begin
          blank_d = ~blank_q;
        end
        if (dimming_q && !blank_q) begin
          // entering the blank phase: resend, counters untouched
          res.start = 1'b1;
        end else begin
          bidx_d = '0;
          if (!three_q || sub_q == 2'd0) begin
            col_n = col_q + 8'd1;
            sub_d = SUB_FIRST;
          end else begin
            sub_d = sub_q - 2'd1;
          end
          if (col_n >= columns_q) begin
            col_n    = '0;
            sub_d    = SUB_FIRST;
            res.sync = 1'b1;
          end
          col_d = col_n;
          if (en_q) begin
            res.pvalid = 1'b1;
            res.start  = 1'b1;
            if (!dimming_q) begin
              res.period = base_q;
            end else if (three_q) begin
              res.period = third;
            end else begin
              res.period = half_dim;
            end
          end
        end
      end
      KIND_BYTE: begin
        res.kind = RES_BYTE;
        if (dimming_q && blank_q) begin
          res.sbyte = BLANK_BYTE;
        end else begin
          res.use_ram = 1'b1;
          fm.re       = 1'b1;
          fm.raddr    = {three_q & sub_q[0], COL_W'(rcol), BYTE_W'(rbyte)};
        end
        if (bnext >= bytes_q || bnext > 5'd15) begin
          bidx_d   = '0;
          res.last = 1'b1;
        end else begin
          bidx_d = bnext[3:0];
        end
      end
      KIND_ENABLE: begin
        col_d  = second_q ? ((columns_q >> 1) - 8'd1) : COL_BEFORE0;
        sub_d  = '0;
        bidx_d = '0;
        en_d   = 1'b1;
      end
      KIND_DISABLE: begin
        en_d = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      sub_q   <= '0;
      bidx_q  <= '0;
      blank_q <= 1'b0;
      en_q    <= 1'b0;
    end else if (accept_i) begin
      col_q   <= col_d;
      sub_q   <= sub_d;
      bidx_q  <= bidx_d;
      blank_q <= blank_d;
      en_q    <= en_d;
    end
  end

  assign res_o     = res;
  assign fmem_o.we    = fm.we & accept_i;
  assign fmem_o.waddr = fm.waddr;
  assign fmem_o.wdata = fm.wdata;
  assign fmem_o.re    = fm.re & accept_i;
  assign fmem_o.raddr = fm.raddr;

endmodule

// ===== rtl/pov_column_scan_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// pov_column_scan_sequencer_top
// Scan sequencer for a rotating POV LED column with a two-plane frame store.
// ----------------------------------------------------------------------------
// Takes one item per clock while in_ready_o is high and returns one result per
// item, in order. An accepted item passes the stage register (with the frame
// store read: a single read port, registered data, used by byte requests) and
// then the output register. Frame writes land in the store at acceptance,
// so a byte request that follows a write in the next cycle already sees the new
// data. The stage ahead of the output register still takes one item while a
// result waits on out_ready_i; after that in_ready_o falls. No clearing pass:
// the frame store must be written before it is read.
module pov_column_scan_sequencer_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [povscan_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [povscan_pkg::CDATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [povscan_pkg::KIND_W-1:0]    kind_i,
  input  logic                              plane_i,
  input  logic [6:0]                        column_addr_i,
  input  logic [3:0]                        byte_addr_i,
  input  logic [7:0]                        pixel_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [povscan_pkg::RKIND_W-1:0]   result_kind_o,
  output logic                              latch_pulse_o,
  output logic                              start_send_o,
  output logic                              period_valid_o,
  output logic [povscan_pkg::PERIOD_W-1:0]  new_period_o,
  output logic                              frame_sync_o,
  output logic [7:0]                        serial_byte_o,
  output logic                              last_byte_o
);
  import povscan_pkg::*;

  logic  accept;
  logic  s1_adv;
  logic  out_free;
  res_t  res;
  fmem_t fmem;
  logic [7:0] rdata;

  logic s1_valid_q, s1_valid_d;
  res_t s1_q;
  logic out_valid_q, out_valid_d;
  res_t out_q, out_d;

  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_free;
  assign in_ready_o = !s1_valid_q || out_free;
  assign accept     = in_valid_i && in_ready_o;

  povscan_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .kind_i        (kind_i),
    .plane_i       (plane_i),
    .column_addr_i (column_addr_i),
    .byte_addr_i   (byte_addr_i),
    .pixel_byte_i  (pixel_byte_i),
    .res_o         (res),
    .fmem_o        (fmem)
  );

  // read data holds while the stage stalls: the next read needs an accept
  povscan_ram #(
    .WIDTH (8),
    .DEPTH (FDEPTH)
  ) u_frame (
    .clk_i   (clk_i),
    .we_i    (fmem.we),
    .waddr_i (fmem.waddr),
    .wdata_i (fmem.wdata),
    .re_i    (fmem.re),
    .raddr_i (fmem.raddr),
    .rdata_o (rdata)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    out_d         = s1_q;
    out_d.use_ram = 1'b0;
    if (s1_q.use_ram) begin
      out_d.sbyte = ~rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q <= res;
    end
    if (s1_adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = out_q.kind;
  assign latch_pulse_o  = out_q.latch;
  assign start_send_o   = out_q.start;
  assign period_valid_o = out_q.pvalid;
  assign new_period_o   = out_q.period;
  assign frame_sync_o   = out_q.sync;
  assign serial_byte_o  = out_q.sbyte;
  assign last_byte_o    = out_q.last;

endmodule

// ===== rtl/povscan_checker.sv =====
// ----------------------------------------------------------------------------
// povscan_checker
// Port-level checks of the POV column scan sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module povscan_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [povscan_pkg::RKIND_W-1:0]   result_kind_o,
  input logic                              latch_pulse_o,
  input logic                              start_send_o,
  input logic                              period_valid_o,
  input logic [povscan_pkg::PERIOD_W-1:0]  new_period_o,
  input logic                              frame_sync_o,
  input logic [7:0]                        serial_byte_o,
  input logic                              last_byte_o
);
  import povscan_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(result_kind_o)
      && $stable(serial_byte_o) && $stable(new_period_o) && $stable(last_byte_o))
    else $error("result changed while stalled");

  // latch, send, period and sync belong to column updates only
  a_column_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RES_COLUMN |->
      !latch_pulse_o && !start_send_o && !period_valid_o && !frame_sync_o)
    else $error("column fields set outside a column update");

  a_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_COLUMN |-> latch_pulse_o)
    else $error("column update without latch");

  // a period is only loaded together with a send start
  a_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (period_valid_o || new_period_o == '0)
      && (!period_valid_o || start_send_o))
    else $error("period field inconsistent");

  a_byte_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o != RES_BYTE |-> serial_byte_o == '0 && !last_byte_o)
    else $error("byte fields set outside a serial byte");

endmodule

bind pov_column_scan_sequencer_top povscan_checker u_povscan_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .result_kind_o  (result_kind_o),
  .latch_pulse_o  (latch_pulse_o),
  .start_send_o   (start_send_o),
  .period_valid_o (period_valid_o),
  .new_period_o   (new_period_o),
  .frame_sync_o   (frame_sync_o),
  .serial_byte_o  (serial_byte_o),
  .last_byte_o    (last_byte_o)
);

// ===== bench/scan_checker.sv =====
// ----------------------------------------------------------------------------
// scan_checker
// Watches both channels and the register port of the scan sequencer. It keeps
// its own copy of the counters, the frame planes and the registers, works out
// the result of every accepted item, and compares it in order with the results
// the block delivers.
// ----------------------------------------------------------------------------
module scan_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [povscan_pkg::CIDX_W-1:0]    cfg_index_i,
  input  logic [povscan_pkg::CDATA_W-1:0]   cfg_wdata_i,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [povscan_pkg::KIND_W-1:0]    kind_i,
  input  logic                              plane_i,
  input  logic [6:0]                        column_addr_i,
  input  logic [3:0]                        byte_addr_i,
  input  logic [7:0]                        pixel_byte_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic [povscan_pkg::RKIND_W-1:0]   result_kind_i,
  input  logic                              latch_pulse_i,
  input  logic                              start_send_i,
  input  logic                              period_valid_i,
  input  logic [povscan_pkg::PERIOD_W-1:0]  new_period_i,
  input  logic                              frame_sync_i,
  input  logic [7:0]                        serial_byte_i,
  input  logic                              last_byte_i,
  output int                                errors_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import povscan_pkg::*;

  typedef struct packed {
    rkind_e              kind;
    logic                latch;
    logic                start;
    logic                pvalid;
    logic [PERIOD_W-1:0] period;
    logic                sync;
    logic [7:0]          sbyte;
    logic                last;
  } scan_result_t;

  // register copies
  logic [7:0]          cols_cfg;
  logic [4:0]          bpc_cfg;
  logic                three_cfg;
  logic                dim_cfg;
  logic [PERIOD_W-1:0] period_cfg;
  logic                second_cfg;

  // sequencer state
  logic [7:0] column_q;
  logic [1:0] subcol_q;
  logic [3:0] byte_q;
  logic       blank_q;
  logic       enabled_q;
  logic [7:0] pixels [2][MAX_COLUMNS][MAX_BYTES];

  scan_result_t expected_q[$];

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors_o++;
  endtask

  function automatic scan_result_t column_tick();
    scan_result_t r;
    logic [PERIOD_W-1:0] half;
    r = '0;
    r.kind = RES_COLUMN;
    r.latch = 1'b1;
    if (dim_cfg) begin
      blank_q = ~blank_q;
      // entering the blank phase: latch and send blanks, counters untouched
      if (blank_q) begin
        r.start = 1'b1;
        return r;
      end
    end
    byte_q = '0;
    if (!three_cfg || subcol_q == 2'd0) begin
      column_q = column_q + 8'd1;
      subcol_q = SUB_FIRST;
    end else begin
      subcol_q = subcol_q - 2'd1;
    end
    if (column_q >= cols_cfg) begin
      column_q = '0;
      subcol_q = SUB_FIRST;
      r.sync = 1'b1;
    end
    if (enabled_q) begin
      half = period_cfg >> 1;
      if (!dim_cfg)
        r.period = period_cfg;
      else if (three_cfg)
        r.period = period_cfg / 16'd3;
      else
        r.period = (half >= DIM_OFFSET) ? half - DIM_OFFSET : '0;
      r.pvalid = 1'b1;
      r.start = 1'b1;
    end
    return r;
  endfunction

  function automatic scan_result_t next_serial_byte();
    scan_result_t r;
    logic       pl;
    logic [7:0] col;
    logic [4:0] nxt;
    r = '0;
    r.kind = RES_BYTE;
    if (dim_cfg && blank_q) begin
      r.sbyte = BLANK_BYTE;
    end else begin
      pl = three_cfg & subcol_q[0];
      // columns are shown in reverse; out of range falls back to entry zero
      col = cols_cfg - column_q;
      if (col >= cols_cfg || col >= MAX_COLUMNS)
        col = '0;
      r.sbyte = ~pixels[pl][col][byte_q];
    end
    nxt = {1'b0, byte_q} + 5'd1;
    if (nxt >= bpc_cfg || nxt > 5'd15) begin
      byte_q = '0;
      r.last = 1'b1;
    end else begin
      byte_q = nxt[3:0];
    end
    return r;
  endfunction

  function automatic scan_result_t predict_item(input logic [KIND_W-1:0] kind,
                                                input logic pl, input logic [6:0] ca,
                                                input logic [3:0] ba, input logic [7:0] pb);
    scan_result_t r;
    r = '0;
    r.kind = RES_ACK;
    case (kind)
      KIND_WRITE:   pixels[pl][ca][ba] = pb;
      KIND_TICK:    r = column_tick();
      KIND_BYTE:    r = next_serial_byte();
      KIND_ENABLE: begin
        column_q  = second_cfg ? (cols_cfg >> 1) - 8'd1 : COL_BEFORE0;
        subcol_q  = '0;
        byte_q    = '0;
        enabled_q = 1'b1;
      end
      KIND_DISABLE: enabled_q = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    scan_result_t want;
    if (!rst_ni) begin
      cols_cfg   = 8'd128;
      bpc_cfg    = 5'd6;
      three_cfg  = 1'b0;
      dim_cfg    = 1'b0;
      period_cfg = 16'hFFFF;
      second_cfg = 1'b0;
      column_q   = '0;
      subcol_q   = '0;
      byte_q     = '0;
      blank_q    = 1'b0;
      enabled_q  = 1'b0;
      expected_q.delete();
      errors_o   = 0;
      pending_o  = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_COLUMNS: cols_cfg   = cfg_wdata_i[7:0];
          CFG_BYTES:   bpc_cfg    = cfg_wdata_i[4:0];
          CFG_THREE:   three_cfg  = cfg_wdata_i[0];
          CFG_DIMMING: dim_cfg    = cfg_wdata_i[0];
          CFG_PERIOD:  period_cfg = cfg_wdata_i;
          CFG_SECOND:  second_cfg = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(predict_item(kind_i, plane_i, column_addr_i,
                                          byte_addr_i, pixel_byte_i));
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result with nothing expected", result_kind_i, 0);
        end else begin
          want = expected_q.pop_front();
          if (result_kind_i !== want.kind)
            report_mismatch("result_kind", result_kind_i, want.kind);
          if (latch_pulse_i !== want.latch)
            report_mismatch("latch_pulse", latch_pulse_i, want.latch);
          if (start_send_i !== want.start)
            report_mismatch("start_send", start_send_i, want.start);
          if (period_valid_i !== want.pvalid)
            report_mismatch("period_valid", period_valid_i, want.pvalid);
          if (new_period_i !== want.period)
            report_mismatch("new_period", new_period_i, want.period);
          if (frame_sync_i !== want.sync)
            report_mismatch("frame_sync", frame_sync_i, want.sync);
          if (serial_byte_i !== want.sbyte)
            report_mismatch("serial_byte", serial_byte_i, want.sbyte);
          if (last_byte_i !== want.last)
            report_mismatch("last_byte", last_byte_i, want.last);
        end
      end
      pending_o = expected_q.size();
    end
  end

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the POV column scan sequencer: fills the low columns of both
// frame planes, runs a short directed sequence, then random column scans under
// several register settings and idle/stall patterns, and reports the checker's
// verdict.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import povscan_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 7;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int LONG_HOLD     = 64;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ITEMS   = 128;
  // random phases keep columns_in_use at or below this, so every read hits
  // a filled entry
  localparam int FILL_COLS     = 16;

  // kind codes the block acknowledges and ignores
  localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;
  localparam logic [KIND_W-1:0] KIND_SPARE_MID   = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_LAST  = 3'd7;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CIDX_W-1:0]   cfg_index_i;
  logic [CDATA_W-1:0]  cfg_wdata_i;
  logic                in_valid_i;
  logic                in_ready_o;
  logic [KIND_W-1:0]   kind_i;
  logic                plane_i;
  logic [6:0]          column_addr_i;
  logic [3:0]          byte_addr_i;
  logic [7:0]          pixel_byte_i;
  logic                out_valid_o;
  logic                out_ready_i;
  logic [RKIND_W-1:0]  result_kind_o;
  logic                latch_pulse_o;
  logic                start_send_o;
  logic                period_valid_o;
  logic [PERIOD_W-1:0] new_period_o;
  logic                frame_sync_o;
  logic [7:0]          serial_byte_o;
  logic                last_byte_o;

  int errors;
  int pending;
  int idle_pct;
  int stall_pct;
  int items_sent;
  int cycle_cnt;
  int cur_bpc;
  logic hold_req;

  pov_column_scan_sequencer_top u_top (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .kind_i, .plane_i, .column_addr_i, .byte_addr_i,
    .pixel_byte_i, .out_valid_o, .out_ready_i, .result_kind_o, .latch_pulse_o,
    .start_send_o, .period_valid_o, .new_period_o, .frame_sync_o,
    .serial_byte_o, .last_byte_o
  );

  scan_checker u_check (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_i(in_ready_o), .kind_i, .plane_i, .column_addr_i,
    .byte_addr_i, .pixel_byte_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .result_kind_i(result_kind_o), .latch_pulse_i(latch_pulse_o),
    .start_send_i(start_send_o), .period_valid_i(period_valid_o),
    .new_period_i(new_period_o), .frame_sync_i(frame_sync_o),
    .serial_byte_i(serial_byte_o), .last_byte_i(last_byte_o),
    .errors_o(errors), .pending_o(pending)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // valid is only lowered when an idle cycle is actually taken
  task automatic offer(input logic [KIND_W-1:0] kind, input logic pl,
                       input logic [6:0] ca, input logic [3:0] ba, input logic [7:0] pb);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    kind_i        <= kind;
    plane_i       <= pl;
    column_addr_i <= ca;
    byte_addr_i   <= ba;
    pixel_byte_i  <= pb;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic offer_op(input logic [KIND_W-1:0] kind);
    offer(kind, 1'($urandom_range(1)), 7'($urandom_range(127)),
          4'($urandom_range(15)), 8'($urandom_range(255)));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_e idx, input logic [CDATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
  endtask

  task automatic setup(input logic [7:0] cols, input logic [4:0] bpc, input logic three,
                       input logic dim, input logic [PERIOD_W-1:0] period,
                       input logic second);
    drain();
    write_reg(CFG_COLUMNS, {8'd0, cols});
    write_reg(CFG_BYTES, {11'd0, bpc});
    write_reg(CFG_THREE, {15'd0, three});
    write_reg(CFG_DIMMING, {15'd0, dim});
    write_reg(CFG_PERIOD, period);
    write_reg(CFG_SECOND, {15'd0, second});
    cfg_we_i <= 1'b0;
    cur_bpc = bpc;
  endtask

  // mostly whole columns: a tick followed by one column of byte requests
  task automatic run_phase(input int n, input int idle, input int stall);
    int target;
    int pick;
    int k;
    idle_pct  = idle;
    stall_pct = stall;
    target = items_sent + n;
    while (items_sent < target) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        offer_op(KIND_TICK);
        for (k = 0; k < cur_bpc; k++) begin
          if ($urandom_range(9) == 0) offer_op(KIND_WRITE);
          offer_op(KIND_BYTE);
        end
      end else if (pick < 82) begin
        offer_op(KIND_WRITE);
      end else if (pick < 84) begin
        offer_op(KIND_ENABLE);
      end else if (pick < 86) begin
        offer_op(KIND_DISABLE);
      end else if (pick < 90) begin
        offer_op(KIND_W'($urandom_range(KIND_SPARE_LAST, KIND_SPARE_FIRST)));
      end else if (pick < 96) begin
        offer_op(KIND_BYTE);
      end else begin
        offer_op(KIND_TICK);
      end
    end
  endtask

  // receiver; one long hold-off lets the block fill and stall its input
  initial begin
    logic hold_done;
    hold_done   = 1'b0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int pl;
    int ca;
    int ba;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = CFG_COLUMNS;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    kind_i        = KIND_WRITE;
    plane_i       = 1'b0;
    column_addr_i = '0;
    byte_addr_i   = '0;
    pixel_byte_i  = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    items_sent    = 0;
    cur_bpc       = 6;
    hold_req      = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // every entry a scan can reach gets written before any read of it
    for (pl = 0; pl < 2; pl++)
      for (ca = 0; ca < FILL_COLS; ca++)
        for (ba = 0; ba < MAX_BYTES; ba++)
          offer(KIND_WRITE, pl[0], ca[6:0], ba[3:0], 8'($urandom_range(255)));

    // directed: disabled request and tick, ignored kinds, out-of-range read
    // right after enable, one full column, extreme writes, a disabled tick
    // and a read of the last column, re-enable
    offer_op(KIND_BYTE);
    offer_op(KIND_TICK);
    offer_op(KIND_SPARE_FIRST);
    offer_op(KIND_SPARE_MID);
    offer_op(KIND_SPARE_LAST);
    offer_op(KIND_ENABLE);
    offer_op(KIND_BYTE);
    offer_op(KIND_TICK);
    repeat (6) offer_op(KIND_BYTE);
    offer(KIND_WRITE, 1'b0, 7'd0, 4'd0, 8'h00);
    offer(KIND_WRITE, 1'b1, 7'd127, 4'd15, 8'hFF);
    offer(KIND_WRITE, 1'b0, 7'd127, 4'd0, 8'($urandom_range(255)));
    offer_op(KIND_DISABLE);
    offer_op(KIND_TICK);
    offer_op(KIND_BYTE);
    offer_op(KIND_ENABLE);
    offer_op(KIND_TICK);
    offer_op(KIND_BYTE);

    setup(8'd16, 5'd16, 1'b1, 1'b1, 16'hFFFF, 1'b1);
    run_phase(PHASE_ITEMS, 0, 0);
    setup(8'd1, 5'd1, 1'b0, 1'b1, 16'd0, 1'b0);
    run_phase(PHASE_ITEMS, 69, 0);
    setup(8'd5, 5'd3, 1'b1, 1'b0, 16'd13, 1'b1);
    run_phase(PHASE_ITEMS, 0, 69);
    setup(8'd16, 5'd6, 1'b0, 1'b1, 16'd14, 1'b0);
    run_phase(PHASE_ITEMS, 8, 8);
    setup(8'd16, 5'd16, 1'b1, 1'b1, 16'($urandom), 1'b0);
    hold_req = 1'b1;
    run_phase(PHASE_ITEMS, 0, 0);
    setup(8'd3, 5'd1, 1'b1, 1'b1, 16'd1, 1'b1);
    run_phase(PHASE_ITEMS, 69, 0);
    setup(8'd12, 5'd9, 1'b0, 1'b0, 16'($urandom), 1'b1);
    run_phase(PHASE_ITEMS, 0, 69);
    setup(8'd2, 5'd16, 1'b0, 1'b1, 16'd6, 1'b0);
    run_phase(PHASE_ITEMS, 8, 8);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    if (errors == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
